### rtl/core/pvh_pkg.sv
`timescale 1ns / 1ps

package pvh_pkg;

    localparam int POS_W  = 16;
    localparam int CIDX_W = 18;
    localparam int CCNT_W = 22;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_READ = 1'b1;

endpackage

### rtl/core/pvh_if.sv
`timescale 1ns / 1ps

interface pvh_in_if;
    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic signed [pvh_pkg::POS_W-1:0]   pos_x;
    logic signed [pvh_pkg::POS_W-1:0]   pos_y;
    logic signed [pvh_pkg::POS_W-1:0]   pos_z;
    logic        [pvh_pkg::CIDX_W-1:0]  cell_index;

    modport source (
        output valid, kind, pos_x, pos_y, pos_z, cell_index,
        input  ready
    );
    modport sink (
        input  valid, kind, pos_x, pos_y, pos_z, cell_index,
        output ready
    );
endinterface

interface pvh_out_if;
    logic                               valid;
    logic                               ready;
    logic        [pvh_pkg::CCNT_W-1:0]  cell_count;

    modport source (
        output valid, cell_count,
        input  ready
    );
    modport sink (
        input  valid, cell_count,
        output ready
    );
endinterface

### rtl/core/pvh_axis.sv
`timescale 1ns / 1ps

module pvh_axis #(
    parameter int GRID_SIZE = 64,
    parameter int FRAC_BITS = 8,
    parameter int CW        = 6
) (
    input  logic signed [pvh_pkg::POS_W-1:0] i_pos,
    output logic                             o_ok,
    output logic        [CW-1:0]             o_lo,
    output logic                             o_two
);

    localparam logic [17:0] HALF  = 18'(1 << (FRAC_BITS - 1));
    localparam logic [16:0] FMASK = 17'((1 << FRAC_BITS) - 1);
    localparam logic [16:0] GMAX  = 17'(GRID_SIZE - 1);

    logic [17:0] q;
    logic [16:0] h;
    logic [16:0] l;
    logic [16:0] hc;
    logic        frac_zero;

    // Shifting by half a cell turns the closed interval test into a floor.
    always_comb begin
        q         = {{2{i_pos[pvh_pkg::POS_W-1]}}, i_pos} + HALF;
        h         = q[16:0] >> FRAC_BITS;
        frac_zero = (q[16:0] & FMASK) == 17'd0;
        l         = (frac_zero && (h != 17'd0)) ? h - 17'd1 : h;
        hc        = (h > GMAX) ? GMAX : h;
        o_ok      = !q[17] && (l <= GMAX);
        o_lo      = l[CW-1:0];
        o_two     = o_ok && (hc != l);
    end

endmodule

### rtl/core/pvh_mem.sv
`timescale 1ns / 1ps

module pvh_mem #(
    parameter int DEPTH = 262144,
    parameter int AW    = 18,
    parameter int DW    = 22
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

endmodule

### rtl/core/particle_voxel_histogram_unit.sv
`timescale 1ns / 1ps
// Add item: its touched cells (one to eight) are updated one per cycle through the
// single read-modify-write path into the counter memory; an item touching no cell is dropped.
// Read item: the memory read is issued in S_RD and its count registered in S_RDW; no item is
// accepted outside S_IDLE. Reset: a clearing pass writes zero to all GRID_SIZE^3 cells, one
// per cycle (262144 cells by default); no item is accepted until it has finished.
module particle_voxel_histogram_unit #(
    parameter int GRID_SIZE   = 64,
    parameter int FRAC_BITS   = 8,
    parameter int COUNT_WIDTH = 22
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pvh_in_if.sink           i_in,
    pvh_out_if.source        o_out
);

    localparam int CW    = $clog2(GRID_SIZE);
    localparam int CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam int CMP_W = 26;

    localparam logic [AW-1:0]          GG        = AW'(GRID_SIZE * GRID_SIZE);
    localparam logic [AW-1:0]          G1        = AW'(GRID_SIZE);
    localparam logic [AW-1:0]          LAST_CELL = AW'(CELLS - 1);
    localparam logic [COUNT_WIDTH-1:0] CMAX      = {COUNT_WIDTH{1'b1}};

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_RDW   = 3'd4;

    logic [2:0]               r_state, n_state;
    logic [AW-1:0]            r_clr;
    logic [2:0]               r_k, n_k;
    logic [2:0]               r_span;
    logic [CW-1:0]            r_x_lo, r_y_lo, r_z_lo;
    logic                     r_wb_valid;
    logic [AW-1:0]            r_wb_addr;
    logic [AW-1:0]            r_rd_addr;
    logic                     r_rd_ok;
    logic                     r_out_valid;
    logic [pvh_pkg::CCNT_W-1:0] r_out_count;

    logic          x_ok, y_ok, z_ok;
    logic          x_two, y_two, z_two;
    logic [CW-1:0] x_lo, y_lo, z_lo;
    logic [CW-1:0] cx, cy, cz;
    logic [AW-1:0] cell_addr;
    logic          in_fire;
    logic          out_fire;

    logic                   mem_rd_en;
    logic [AW-1:0]          mem_rd_addr;
    logic [COUNT_WIDTH-1:0] mem_rd_data;
    logic                   mem_wr_en;
    logic [AW-1:0]          mem_wr_addr;
    logic [COUNT_WIDTH-1:0] mem_wr_data;

    pvh_axis #(.GRID_SIZE(GRID_SIZE), .FRAC_BITS(FRAC_BITS), .CW(CW)) u_axis_x (
        .i_pos(i_in.pos_x), .o_ok(x_ok), .o_lo(x_lo), .o_two(x_two)
    );
    pvh_axis #(.GRID_SIZE(GRID_SIZE), .FRAC_BITS(FRAC_BITS), .CW(CW)) u_axis_y (
        .i_pos(i_in.pos_y), .o_ok(y_ok), .o_lo(y_lo), .o_two(y_two)
    );
    pvh_axis #(.GRID_SIZE(GRID_SIZE), .FRAC_BITS(FRAC_BITS), .CW(CW)) u_axis_z (
        .i_pos(i_in.pos_z), .o_ok(z_ok), .o_lo(z_lo), .o_two(z_two)
    );

    pvh_mem #(.DEPTH(CELLS), .AW(AW), .DW(COUNT_WIDTH)) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    assign i_in.ready = (r_state == S_IDLE) &&
                        ((i_in.kind == pvh_pkg::KIND_ADD) || !r_out_valid || o_out.ready);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_fire   = o_out.valid && o_out.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.cell_count = r_out_count;

    always_comb begin
        cx        = r_x_lo + CW'(r_k[0]);
        cy        = r_y_lo + CW'(r_k[1]);
        cz        = r_z_lo + CW'(r_k[2]);
        cell_addr = AW'(cz) * GG + AW'(cy) * G1 + AW'(cx);
        n_k       = ((r_k | ~r_span) + 3'd1) & r_span;
    end

    always_comb begin
        mem_rd_en   = (r_state == S_ADD) || ((r_state == S_RD) && r_rd_ok);
        mem_rd_addr = (r_state == S_ADD) ? cell_addr : r_rd_addr;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_rd_addr;
        mem_wr_data = '0;
        if (r_state == S_CLEAR) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = r_clr;
        end else if (r_wb_valid) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = r_wb_addr;
            mem_wr_data = (mem_rd_data == CMAX) ? CMAX : mem_rd_data + COUNT_WIDTH'(1);
        end else if ((r_state == S_RD) && r_rd_ok) begin
            mem_wr_en   = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == LAST_CELL) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.kind == pvh_pkg::KIND_READ) begin
                        n_state = S_RD;
                    end else if (x_ok && y_ok && z_ok) begin
                        n_state = S_ADD;
                    end
                end
            end
            S_ADD: begin
                if (r_k == r_span) begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_RDW;
            end
            S_RDW: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_k         <= '0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wb_valid <= (r_state == S_ADD);
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_state == S_IDLE) begin
                r_k <= '0;
            end else if (r_state == S_ADD) begin
                r_k <= n_k;
            end
            if (r_state == S_RDW) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x_lo    <= x_lo;
            r_y_lo    <= y_lo;
            r_z_lo    <= z_lo;
            r_span    <= {z_two, y_two, x_two};
            r_rd_addr <= AW'(i_in.cell_index);
            r_rd_ok   <= CMP_W'(i_in.cell_index) < CMP_W'(CELLS);
        end
        r_wb_addr <= cell_addr;
        if (r_state == S_RDW) begin
            r_out_count <= r_rd_ok ? pvh_pkg::CCNT_W'(mem_rd_data) : '0;
        end
    end

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_in.ready)
        else $error("item accepted during the clearing pass");

    a_wb_not_with_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_valid |-> (r_state != S_RD) && (r_state != S_CLEAR))
        else $error("write-back collides with another memory write");

    a_out_free_for_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDW) |-> !r_out_valid)
        else $error("read result would overwrite a waiting result");

    a_k_within_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> ((r_k & ~r_span) == 3'd0))
        else $error("cell offset outside the touched span");

endmodule
